FILE: rtl/tlba_pkg.sv
// ----------------------------------------------------------------------------
// tlba_pkg
// shared types, codes and defaults for the two-level bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package tlba_pkg;

    localparam int DEF_MAP_BITS      = 4096;
    localparam int DEF_WORD_BITS     = 32;
    localparam int DEF_SEARCH_WINDOW = 2048;

    localparam int REQ_TYPE_W  = 3;
    localparam int BIT_INDEX_W = 12;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 13;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_SET       = 3'd0,
        REQ_CLEAR     = 3'd1,
        REQ_TEST      = 3'd2,
        REQ_ALLOC     = 3'd3,
        REQ_SET_ALL   = 3'd4,
        REQ_CLEAR_ALL = 3'd5
    } req_code_t;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]  req_type;
        logic [BIT_INDEX_W-1:0] bit_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   bit_state;
        logic [BIT_INDEX_W-1:0] alloc_index;
        logic [COUNT_W-1:0]     free_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WIN,
        S_SCAN,
        S_DATA,
        S_ADV,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/tlba_ram.sv
// ----------------------------------------------------------------------------
// tlba_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tlba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/two_level_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// two_level_bitmap_allocator_top
// bitmap allocator with one summary bit per map word marking a full word
// ----------------------------------------------------------------------------
// One item at a time. Set, clear and test pass through accept, one ram read
// and update, then the load of the output register. Set all, clear all,
// out-of-range and unused codes skip the ram step. An allocate walks the map
// one word at a time through the single ram read port: a word whose summary
// bit marks it full is skipped without a read, any other word is read, then
// searched, and each search window adds a window setup and an end of window
// step, with one advance step per up/down pair. Set all, clear all and a
// map_size write act at once through per-word valid bits; there is no
// clearing pass.
`default_nettype none

module two_level_bitmap_allocator_top #(
    parameter int MAP_BITS      = tlba_pkg::DEF_MAP_BITS,
    parameter int WORD_BITS     = tlba_pkg::DEF_WORD_BITS,
    parameter int SEARCH_WINDOW = tlba_pkg::DEF_SEARCH_WINDOW
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire tlba_pkg::req_t            req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output tlba_pkg::rsp_t                 rsp,
    input  wire logic                      cfg_we,
    input  wire logic [tlba_pkg::COUNT_W-1:0] cfg_wdata
);

    import tlba_pkg::*;

    localparam int WL   = $clog2(WORD_BITS);
    localparam int NW   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int SZ_W = $clog2(MAP_BITS + 1);
    localparam int PW   = $clog2(MAP_BITS + SEARCH_WINDOW + 1) + 1;

    function automatic logic [WORD_BITS-1:0] used_mask(input logic [AW-1:0] w,
                                                       input logic [SZ_W-1:0] sz);
        int base;
        int rem;
        base = int'(w) * WORD_BITS;
        rem  = int'(sz) - base;
        if (rem <= 0)
            return '0;
        else if (rem >= WORD_BITS)
            return '1;
        else
            return {WORD_BITS{1'b1}} >> (WORD_BITS - rem);
    endfunction

    function automatic logic [NW-1:0] beyond_map(input logic [SZ_W-1:0] sz);
        logic [NW-1:0] b;
        for (int i = 0; i < NW; i++)
        begin
            b[i] = (i * WORD_BITS >= int'(sz));
        end
        return b;
    endfunction

    state_t                  state_reg, state_next;
    logic [REQ_TYPE_W-1:0]   type_reg, type_next;
    logic [BIT_INDEX_W-1:0]  idx_reg, idx_next;
    logic [SZ_W-1:0]         size_reg, size_next;
    logic [SZ_W-1:0]         free_reg, free_next;
    logic                    fill_reg, fill_next;
    logic [NW-1:0]           valid_reg, valid_next;
    logic [NW-1:0]           sum_reg, sum_next;
    logic [AW-1:0]           w_reg, w_next;
    logic signed [PW-1:0]    pos_reg, pos_next;
    logic signed [PW-1:0]    lim_reg, lim_next;
    logic signed [PW-1:0]    up_reg, up_next;
    logic signed [PW-1:0]    down_reg, down_next;
    logic                    dir_reg, dir_next;
    logic [STATUS_W-1:0]     st_reg, st_next;
    logic                    bs_reg, bs_next;
    logic [BIT_INDEX_W-1:0]  ai_reg, ai_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic [AW-1:0]           raddr;
    logic [WORD_BITS-1:0]    rdata;
    logic                    ram_we;
    logic [WORD_BITS-1:0]    new_word;
    logic [WORD_BITS-1:0]    word_cur;
    logic [WORD_BITS-1:0]    um_cur;
    logic [WORD_BITS-1:0]    free_mask;
    logic [WL-1:0]           hit_off;
    logic                    hit_any;
    logic [WL-1:0]           mod_off;
    logic                    mod_set;
    logic                    bit_old;
    logic signed [PW-1:0]    sz_s;
    logic [AW-1:0]           w_pos;
    logic [PW-1:0]           pos_shift;
    logic [SZ_W-1:0]         cfg_sat;
    logic                    accept;
    logic                    in_range;
    logic signed [PW-1:0]    up_adv, down_adv;

    tlba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW),
        .ADDR_W(AW)
    ) u_map_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(w_reg),
        .wdata(new_word),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign sz_s      = signed'(PW'(size_reg));
    assign pos_shift = PW'(pos_reg) >> WL;
    assign w_pos     = AW'(pos_shift);
    assign accept    = req_valid && req_ready;
    assign in_range  = 32'(req.bit_index) < 32'(size_reg);
    assign um_cur    = used_mask(w_reg, size_reg);

    // a word never written since the last fill reads as the fill pattern
    assign word_cur = valid_reg[w_reg] ? rdata : (fill_reg ? um_cur : '0);

    assign cfg_sat = (cfg_wdata == '0) ? SZ_W'(1) :
                     (32'(cfg_wdata) > MAP_BITS) ? SZ_W'(MAP_BITS) : SZ_W'(cfg_wdata);

    // free bits of the current word that lie inside the window
    always_comb
    begin
        int g;
        free_mask = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            g = int'(w_reg) * WORD_BITS + b;
            if (!dir_reg)
                free_mask[b] = !word_cur[b] && um_cur[b] &&
                               (g >= int'(pos_reg)) && (g <= int'(lim_reg));
            else
                free_mask[b] = !word_cur[b] && um_cur[b] &&
                               (g <= int'(pos_reg)) && (g >= int'(lim_reg));
        end
    end

    // lowest free bit going up, highest going down
    always_comb
    begin
        hit_off = '0;
        if (!dir_reg)
        begin
            for (int b = WORD_BITS - 1; b >= 0; b--)
            begin
                if (free_mask[b])
                    hit_off = WL'(b);
            end
        end
        else
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                if (free_mask[b])
                    hit_off = WL'(b);
            end
        end
    end

    assign hit_any = |free_mask;
    assign mod_off = (state_reg == S_MOD) ? WL'(idx_reg) : hit_off;
    assign mod_set = (state_reg == S_MOD) ? (type_reg == REQ_SET) : 1'b1;
    assign bit_old = word_cur[mod_off];
    assign new_word = mod_set ? (word_cur | (WORD_BITS'(1) << mod_off)) :
                                (word_cur & ~(WORD_BITS'(1) << mod_off));
    assign ram_we = ((state_reg == S_MOD) && (type_reg != REQ_TEST)) ||
                    ((state_reg == S_DATA) && hit_any);

    assign up_adv   = (up_reg < sz_s) ? up_reg + PW'(SEARCH_WINDOW) : up_reg;
    assign down_adv = (down_reg >= 0) ? down_reg - PW'(SEARCH_WINDOW) : down_reg;

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        idx_next       = idx_reg;
        size_next      = size_reg;
        free_next      = free_reg;
        fill_next      = fill_reg;
        valid_next     = valid_reg;
        sum_next       = sum_reg;
        w_next         = w_reg;
        pos_next       = pos_reg;
        lim_next       = lim_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        dir_next       = dir_reg;
        st_next        = st_reg;
        bs_next        = bs_reg;
        ai_next        = ai_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        raddr          = w_pos;
        req_ready      = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                raddr = AW'(req.bit_index >> WL);
                if (accept)
                begin
                    type_next = req.req_type;
                    idx_next  = req.bit_index;
                    w_next    = AW'(req.bit_index >> WL);
                    st_next   = STATUS_OK;
                    bs_next   = 1'b0;
                    ai_next   = '0;
                    up_next   = signed'(PW'(req.bit_index));
                    down_next = signed'(PW'(req.bit_index));
                    dir_next  = 1'b0;
                    state_next = S_DONE;
                    case (req.req_type)
                        REQ_SET, REQ_CLEAR, REQ_TEST:
                        begin
                            if (in_range)
                                state_next = S_MOD;
                            else
                                st_next = STATUS_RANGE;
                        end
                        REQ_ALLOC:
                        begin
                            if (in_range)
                                state_next = S_WIN;
                            else
                                st_next = STATUS_RANGE;
                        end
                        REQ_SET_ALL:
                        begin
                            fill_next  = 1'b1;
                            valid_next = '0;
                            sum_next   = '1;
                            free_next  = '0;
                        end
                        REQ_CLEAR_ALL:
                        begin
                            fill_next  = 1'b0;
                            valid_next = '0;
                            sum_next   = beyond_map(size_reg);
                            free_next  = size_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (type_reg == REQ_TEST)
                    bs_next = bit_old;
                state_next = S_DONE;
            end
            S_WIN:
            begin
                if (!dir_reg)
                begin
                    if (up_reg < sz_s)
                    begin
                        pos_next = up_reg;
                        lim_next = (up_reg + PW'(SEARCH_WINDOW) > sz_s - 1) ? sz_s - 1 :
                                   up_reg + PW'(SEARCH_WINDOW);
                        state_next = S_SCAN;
                    end
                    else
                        dir_next = 1'b1;
                end
                else
                begin
                    if (down_reg >= 0)
                    begin
                        pos_next = down_reg;
                        lim_next = (down_reg - PW'(SEARCH_WINDOW) < 0) ? '0 :
                                   down_reg - PW'(SEARCH_WINDOW);
                        state_next = S_SCAN;
                    end
                    else
                        state_next = S_ADV;
                end
            end
            S_SCAN:
            begin
                w_next = w_pos;
                if ((!dir_reg && pos_reg > lim_reg) || (dir_reg && pos_reg < lim_reg))
                begin
                    // window exhausted
                    if (!dir_reg)
                    begin
                        dir_next   = 1'b1;
                        state_next = S_WIN;
                    end
                    else
                        state_next = S_ADV;
                end
                else if (sum_reg[w_pos])
                begin
                    // full word, skip without a read
                    if (!dir_reg)
                        pos_next = signed'(PW'((32'(w_pos) + 32'd1) << WL));
                    else
                        pos_next = signed'(PW'(32'(w_pos) << WL)) - PW'(1);
                end
                else
                    state_next = S_DATA;
            end
            S_DATA:
            begin
                if (hit_any)
                begin
                    ai_next    = BIT_INDEX_W'((32'(w_reg) << WL) + 32'(hit_off));
                    state_next = S_DONE;
                end
                else
                begin
                    if (!dir_reg)
                        pos_next = signed'(PW'((32'(w_reg) + 32'd1) << WL));
                    else
                        pos_next = signed'(PW'(32'(w_reg) << WL)) - PW'(1);
                    state_next = S_SCAN;
                end
            end
            S_ADV:
            begin
                up_next   = up_adv;
                down_next = down_adv;
                dir_next  = 1'b0;
                if (up_adv < sz_s || down_adv >= 0)
                    state_next = S_WIN;
                else
                begin
                    st_next    = STATUS_NO_FREE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = st_reg;
                    rsp_next.bit_state   = bs_reg;
                    rsp_next.alloc_index = ai_reg;
                    rsp_next.free_count  = COUNT_W'(free_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[w_reg] = 1'b1;
            sum_next[w_reg]   = ((new_word & um_cur) == um_cur);
            if (mod_set && !bit_old && free_reg != '0)
                free_next = free_reg - SZ_W'(1);
            else if (!mod_set && bit_old && free_reg < size_reg)
                free_next = free_reg + SZ_W'(1);
        end

        if (cfg_we)
        begin
            size_next  = cfg_sat;
            fill_next  = 1'b0;
            valid_next = '0;
            sum_next   = beyond_map(cfg_sat);
            free_next  = cfg_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SZ_W'(MAP_BITS);
            free_reg      <= SZ_W'(MAP_BITS);
            fill_reg      <= 1'b0;
            valid_reg     <= '0;
            sum_reg       <= beyond_map(SZ_W'(MAP_BITS));
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            free_reg      <= free_next;
            fill_reg      <= fill_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        idx_reg  <= idx_next;
        w_reg    <= w_next;
        pos_reg  <= pos_next;
        lim_reg  <= lim_next;
        up_reg   <= up_next;
        down_reg <= down_next;
        dir_reg  <= dir_next;
        st_reg   <= st_next;
        bs_reg   <= bs_next;
        ai_reg   <= ai_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_free_le_size: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= size_reg)
        else $error("free count above map size");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while busy");

    a_read_only_open_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> !sum_reg[w_reg])
        else $error("full word read during search");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) && hit_any |=> 32'(ai_reg) < 32'(size_reg))
        else $error("allocated bit beyond map size");
`endif

endmodule

`default_nettype wire
